>>> rtl/core/priority_ready_queue_scheduler_macros.svh
// assertion helpers, sampled on clk with the async reset as disable
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// plain property check
`define PRQS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the following cycle
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/prqs_pkg.sv
`default_nettype none
package prqs_pkg;

	localparam int TASKS  = 32;
	localparam int LEVELS = 16;
	localparam int TASK_W = $clog2(TASKS);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int MODE_W = 2;
	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;

	localparam logic [MODE_W-1:0] MODE_READY   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNREADY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIO    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ROTATE  = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_FETCH,
		OP_UNLINK,
		OP_LINK_TAIL,
		OP_LINK_HEAD,
		OP_TOP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   use_old;
		logic   set_lvl;
		logic   rdy_set;
		logic   rdy_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic              tsk_ready;
		logic              rot_ok;
		logic              top_valid;
		logic              top_is_tsk;
		logic              pri_lt_top;
		logic              pri_eq_top;
		logic              mtx;
		logic [TASK_W-1:0] top_task;
		logic [LVL_W-1:0]  top_level;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/prqs_datapath.sv
`default_nettype none
module prqs_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [prqs_pkg::TASK_W-1:0] in_task,
	input  wire logic [prqs_pkg::LVL_W-1:0]  in_pri,
	input  wire logic                       in_mtx,
	input  wire prqs_pkg::dp_cmd_t          cmd,
	output prqs_pkg::dp_stat_t              stat
);

	logic [prqs_pkg::LEVELS-1:0] bitmap_q;
	logic [prqs_pkg::TASKS-1:0]  rdy_q;
	logic [prqs_pkg::TASK_W-1:0] head_q [prqs_pkg::LEVELS];
	logic [prqs_pkg::TASK_W-1:0] tail_q [prqs_pkg::LEVELS];
	logic [prqs_pkg::TASK_W-1:0] next_q [prqs_pkg::TASKS];
	logic [prqs_pkg::TASK_W-1:0] prev_q [prqs_pkg::TASKS];
	logic [prqs_pkg::LVL_W-1:0]  lvl_q  [prqs_pkg::TASKS];
	logic [prqs_pkg::TASK_W-1:0] tsk_q;
	logic [prqs_pkg::LVL_W-1:0]  pri_q;
	logic [prqs_pkg::LVL_W-1:0]  old_q;
	logic                        mtx_q;
	logic                        top_valid_q;
	logic [prqs_pkg::TASK_W-1:0] top_task_q;
	logic [prqs_pkg::LVL_W-1:0]  top_level_q;

	logic [prqs_pkg::LVL_W-1:0]  ulv;
	logic [prqs_pkg::TASK_W-1:0] p_idx, n_idx;
	logic                        was_head, was_tail;
	logic [prqs_pkg::LVL_W-1:0]  low_lv;

	assign ulv      = cmd.use_old ? old_q : pri_q;
	assign p_idx    = prev_q[tsk_q];
	assign n_idx    = next_q[tsk_q];
	assign was_head = head_q[ulv] == tsk_q;
	assign was_tail = tail_q[ulv] == tsk_q;

	// lowest set level
	always_comb begin
		low_lv = '0;
		for (int i = prqs_pkg::LEVELS - 1; i >= 0; i--) begin
			if (bitmap_q[i]) begin
				low_lv = prqs_pkg::LVL_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			prqs_pkg::OP_LOAD: begin
				tsk_q <= in_task;
				pri_q <= in_pri;
				old_q <= lvl_q[in_task];
				mtx_q <= in_mtx;
			end
			prqs_pkg::OP_FETCH: begin
				tsk_q <= head_q[pri_q];
			end
			prqs_pkg::OP_UNLINK: begin
				if (!(was_head && was_tail)) begin
					if (was_head) begin
						head_q[ulv] <= n_idx;
					end else begin
						next_q[p_idx] <= n_idx;
					end
					if (was_tail) begin
						tail_q[ulv] <= p_idx;
					end else begin
						prev_q[n_idx] <= p_idx;
					end
				end
			end
			prqs_pkg::OP_LINK_TAIL: begin
				if (!bitmap_q[pri_q]) begin
					head_q[pri_q] <= tsk_q;
				end else begin
					next_q[tail_q[pri_q]] <= tsk_q;
					prev_q[tsk_q] <= tail_q[pri_q];
				end
				tail_q[pri_q] <= tsk_q;
			end
			prqs_pkg::OP_LINK_HEAD: begin
				if (!bitmap_q[pri_q]) begin
					tail_q[pri_q] <= tsk_q;
				end else begin
					prev_q[head_q[pri_q]] <= tsk_q;
					next_q[tsk_q] <= head_q[pri_q];
				end
				head_q[pri_q] <= tsk_q;
			end
			default: begin
			end
		endcase
		if (cmd.set_lvl) begin
			lvl_q[tsk_q] <= pri_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q    <= '0;
			rdy_q       <= '0;
			top_valid_q <= 1'b0;
			top_task_q  <= '0;
			top_level_q <= '0;
		end else begin
			if (cmd.rdy_set) begin
				rdy_q[tsk_q] <= 1'b1;
			end
			if (cmd.rdy_clr) begin
				rdy_q[tsk_q] <= 1'b0;
			end
			case (cmd.op) inside
				prqs_pkg::OP_UNLINK: begin
					if (was_head && was_tail) begin
						bitmap_q[ulv] <= 1'b0;
					end
				end
				prqs_pkg::OP_LINK_TAIL, prqs_pkg::OP_LINK_HEAD: begin
					bitmap_q[pri_q] <= 1'b1;
				end
				prqs_pkg::OP_TOP: begin
					top_valid_q <= |bitmap_q;
					top_task_q  <= (|bitmap_q) ? head_q[low_lv] : '0;
					top_level_q <= (|bitmap_q) ? low_lv : '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.tsk_ready  = rdy_q[tsk_q];
		stat.rot_ok     = bitmap_q[pri_q] && (head_q[pri_q] != tail_q[pri_q]);
		stat.top_valid  = top_valid_q;
		stat.top_is_tsk = top_task_q == tsk_q;
		stat.pri_lt_top = pri_q < top_level_q;
		stat.pri_eq_top = pri_q == top_level_q;
		stat.mtx        = mtx_q;
		stat.top_task   = top_task_q;
		stat.top_level  = top_level_q;
	end

endmodule
`default_nettype wire

>>> rtl/core/prqs_ctrl.sv
`default_nettype none
`include "priority_ready_queue_scheduler_macros.svh"
module prqs_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [prqs_pkg::MODE_W-1:0] in_mode,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [prqs_pkg::OUT_W-1:0]       out_data,
	output prqs_pkg::dp_cmd_t                cmd,
	input  wire prqs_pkg::dp_stat_t          stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ROT,
		ST_UNLINK,
		ST_LINK,
		ST_TOP,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [prqs_pkg::MODE_W-1:0] mode_q;
	logic                        chg_q;
	logic                        err_q;
	logic                        out_valid_q;
	logic [prqs_pkg::OUT_W-1:0]  out_data_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		cmd = '{op: prqs_pkg::OP_NONE, use_old: 1'b0, set_lvl: 1'b0,
			rdy_set: 1'b0, rdy_clr: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = prqs_pkg::OP_LOAD;
				end
			end
			ST_DECODE: begin
				unique case (mode_q)
					prqs_pkg::MODE_READY: begin
						cmd.set_lvl = !stat.tsk_ready;
						cmd.rdy_set = !stat.tsk_ready;
					end
					prqs_pkg::MODE_UNREADY: begin
						cmd.rdy_clr = stat.tsk_ready;
					end
					prqs_pkg::MODE_PRIO: begin
						cmd.set_lvl = 1'b1;
					end
					default: begin
						cmd.op = prqs_pkg::OP_FETCH;
					end
				endcase
			end
			ST_UNLINK: begin
				cmd.op      = prqs_pkg::OP_UNLINK;
				cmd.use_old = mode_q != prqs_pkg::MODE_ROTATE;
			end
			ST_LINK: begin
				cmd.op = (mode_q == prqs_pkg::MODE_PRIO && stat.mtx) ?
					prqs_pkg::OP_LINK_HEAD : prqs_pkg::OP_LINK_TAIL;
			end
			ST_TOP: begin
				cmd.op = prqs_pkg::OP_TOP;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= prqs_pkg::MODE_READY;
			chg_q       <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// a taken result is dropped unless done reloads the register
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= in_mode;
						chg_q   <= 1'b0;
						err_q   <= 1'b0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (mode_q)
						prqs_pkg::MODE_READY: begin
							if (stat.tsk_ready) begin
								err_q   <= 1'b1;
								state_q <= ST_TOP;
							end else begin
								chg_q   <= !stat.top_valid || stat.pri_lt_top;
								state_q <= ST_LINK;
							end
						end
						prqs_pkg::MODE_UNREADY: begin
							if (!stat.tsk_ready) begin
								err_q   <= 1'b1;
								state_q <= ST_TOP;
							end else begin
								chg_q   <= stat.top_valid && stat.top_is_tsk;
								state_q <= ST_UNLINK;
							end
						end
						prqs_pkg::MODE_PRIO: begin
							if (stat.tsk_ready) begin
								chg_q <= (stat.top_valid && stat.top_is_tsk) ||
									stat.pri_lt_top || (stat.mtx && stat.pri_eq_top);
								state_q <= ST_UNLINK;
							end else begin
								state_q <= ST_TOP;
							end
						end
						default: begin
							state_q <= ST_ROT;
						end
					endcase
				end
				ST_ROT: begin
					if (stat.rot_ok) begin
						chg_q   <= stat.top_valid && stat.top_is_tsk;
						state_q <= ST_UNLINK;
					end else begin
						state_q <= ST_TOP;
					end
				end
				ST_UNLINK: begin
					state_q <= (mode_q == prqs_pkg::MODE_UNREADY) ? ST_TOP : ST_LINK;
				end
				ST_LINK: begin
					state_q <= ST_TOP;
				end
				ST_TOP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {4'b0000, err_q, chg_q, stat.top_level,
							stat.top_task, stat.top_valid};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a rejected request never reports a top change
	`PRQS_ASSERT(a_err_no_chg, !(out_valid_q && out_data_q[11] && out_data_q[10]), "error with change")
	// empty queue reports zero task and level
	`PRQS_ASSERT(a_empty_zero, !(out_valid_q && !out_data_q[0] && (out_data_q[9:1] != '0)), "empty top not zero")
	// one request at a time
	`PRQS_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready, "second item taken while busy")
	// a result is only produced after the top refresh
	`PRQS_ASSERT_NEXT(a_top_first, state_q == ST_TOP, state_q == ST_DONE, "top refresh skipped")

endmodule
`default_nettype wire

>>> rtl/core/priority_ready_queue_scheduler.sv
`default_nettype none
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata: task_id, priority_req, mutex_mode; s_tuser: mode
// m_axis    out  m_tvalid/m_tready  m_tdata: top_valid, top_task, top_level, top_changed, error
//
// one request at a time: decode, the mode's steps, top refresh, done (rejected or level-only
// none, make ready link, make not ready unlink, requeue unlink then link, rotate a check,
// then unlink and link if it passes), one link update per cycle through the arrays;
// the result waits in an output register; the sequencer is idle again as it turns valid,
// so the next item may be taken in the next cycle; a full register stalls done
// reset clears the ready bitmap, ready flags and top; link arrays need none
module priority_ready_queue_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // task_id[4:0], priority_req[8:5], mutex_mode[9]
	input  wire logic [1:0]  s_tuser,  // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // top_valid[0], top_task[5:1], top_level[9:6],
	                                   // top_changed[10], error[11]
);

	prqs_pkg::dp_cmd_t  cmd;
	prqs_pkg::dp_stat_t stat;

	// sequencer and result register
	prqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	// queues, links, bitmap and top registers
	prqs_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_task (s_tdata[4:0]),
		.in_pri  (s_tdata[8:5]),
		.in_mtx  (s_tdata[9]),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule
`default_nettype wire

>>> sim/scheduler_checker.sv
`timescale 1ns / 100ps
module scheduler_checker
	import prqs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	output int               fails,
	output int               pending
);

	// same bit order as m_tdata[11:0]
	typedef struct packed {
		logic             err;
		logic             chg;
		logic [LVL_W-1:0] lvl;
		logic [TASK_W-1:0] tsk;
		logic             vld;
	} top_report_t;

	top_report_t expected_tops[$];

	logic [LEVELS-1:0] rdy_map;
	logic [TASK_W-1:0] head_of [LEVELS];
	logic [TASK_W-1:0] tail_of [LEVELS];
	logic [TASK_W-1:0] nxt [TASKS];
	logic [TASK_W-1:0] prv [TASKS];
	logic [LVL_W-1:0]  lvl_of [TASKS];
	logic              is_rdy [TASKS];
	logic              top_v;
	logic [TASK_W-1:0] top_t;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic top_from_map();
		top_v = 1'b0;
		top_t = '0;
		for (int lv = LEVELS - 1; lv >= 0; lv--) begin
			if (rdy_map[lv]) begin
				top_v = 1'b1;
				top_t = head_of[lv];
			end
		end
	endtask

	task automatic unlink(input logic [TASK_W-1:0] t, input logic [LVL_W-1:0] lv);
		logic [TASK_W-1:0] p, n;
		logic wh, wt;
		p = prv[t];
		n = nxt[t];
		wh = head_of[lv] == t;
		wt = tail_of[lv] == t;
		if (wh && wt) begin
			rdy_map[lv] = 1'b0;
			return;
		end
		if (wh) head_of[lv] = n;
		else nxt[p] = n;
		if (wt) tail_of[lv] = p;
		else prv[n] = p;
	endtask

	task automatic link_at_tail(input logic [TASK_W-1:0] t, input logic [LVL_W-1:0] lv);
		if (!rdy_map[lv]) begin
			head_of[lv] = t;
		end else begin
			nxt[tail_of[lv]] = t;
			prv[t] = tail_of[lv];
		end
		tail_of[lv] = t;
		rdy_map[lv] = 1'b1;
	endtask

	task automatic link_at_head(input logic [TASK_W-1:0] t, input logic [LVL_W-1:0] lv);
		if (!rdy_map[lv]) begin
			tail_of[lv] = t;
		end else begin
			prv[head_of[lv]] = t;
			nxt[t] = head_of[lv];
		end
		head_of[lv] = t;
		rdy_map[lv] = 1'b1;
	endtask

	// one request in, the reported top out
	task automatic schedule_request(input logic [1:0] mode, input logic [TASK_W-1:0] t,
			input logic [LVL_W-1:0] pri, input logic mtx, output top_report_t r);
		logic err, chg;
		logic [LVL_W-1:0] old_lv, e;
		logic [TASK_W-1:0] h;
		err = 1'b0;
		chg = 1'b0;
		case (mode)
			MODE_READY: begin
				if (is_rdy[t]) begin
					err = 1'b1;
				end else begin
					lvl_of[t] = pri;
					is_rdy[t] = 1'b1;
					link_at_tail(t, pri);
					if (!top_v || pri < lvl_of[top_t]) begin
						top_v = 1'b1;
						top_t = t;
						chg = 1'b1;
					end
				end
			end
			MODE_UNREADY: begin
				if (!is_rdy[t]) begin
					err = 1'b1;
				end else begin
					old_lv = lvl_of[t];
					is_rdy[t] = 1'b0;
					unlink(t, old_lv);
					if (top_v && top_t == t) begin
						if (!rdy_map[old_lv]) top_from_map();
						else top_t = head_of[old_lv];
						chg = 1'b1;
					end
				end
			end
			MODE_PRIO: begin
				old_lv = lvl_of[t];
				lvl_of[t] = pri;
				if (is_rdy[t]) begin
					unlink(t, old_lv);
					if (mtx) link_at_head(t, pri);
					else link_at_tail(t, pri);
					if (top_v && top_t == t) begin
						if (pri >= old_lv) top_from_map();
						chg = 1'b1;
					end else if (mtx ? pri <= lvl_of[top_t] : pri < lvl_of[top_t]) begin
						top_v = 1'b1;
						top_t = t;
						chg = 1'b1;
					end
				end
			end
			default: begin
				// rotate only when the level holds two or more tasks
				if (rdy_map[pri] && head_of[pri] != tail_of[pri]) begin
					h = head_of[pri];
					unlink(h, pri);
					link_at_tail(h, pri);
					if (top_v && top_t == h) begin
						top_t = head_of[pri];
						chg = 1'b1;
					end
				end
			end
		endcase
		r.vld = top_v;
		r.tsk = top_v ? top_t : '0;
		r.lvl = top_v ? lvl_of[top_t] : '0;
		r.chg = chg;
		r.err = err;
	endtask

	always @(posedge clk or negedge arst_n) begin
		top_report_t r, want;
		if (!arst_n) begin
			rdy_map = '0;
			top_v = 1'b0;
			top_t = '0;
			for (int i = 0; i < TASKS; i++) begin
				is_rdy[i] = 1'b0;
				nxt[i] = '0;
				prv[i] = '0;
				lvl_of[i] = '0;
			end
			for (int i = 0; i < LEVELS; i++) begin
				head_of[i] = '0;
				tail_of[i] = '0;
			end
			expected_tops.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				schedule_request(s_tuser, s_tdata[4:0], s_tdata[8:5], s_tdata[9], r);
				expected_tops.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (expected_tops.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					want = expected_tops.pop_front();
					r = m_tdata[11:0];
					if (r.vld !== want.vld) report("top_valid", r.vld, want.vld);
					if (r.tsk !== want.tsk) report("top_task", r.tsk, want.tsk);
					if (r.lvl !== want.lvl) report("top_level", r.lvl, want.lvl);
					if (r.chg !== want.chg) report("top_changed", r.chg, want.chg);
					if (r.err !== want.err) report("error", r.err, want.err);
				end
			end
			pending = expected_tops.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import prqs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // task_id[4:0], priority_req[8:5], mutex_mode[9]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // top_valid[0], top_task[5:1], top_level[9:6], top_changed[10], error[11]
	int          fails;
	int          pending;
	int          sent;

	priority_ready_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	scheduler_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

	// one item per call: random gap, then hold until accepted
	task automatic send_request(input logic [1:0] mode, input logic [4:0] tid,
			input logic [3:0] pri, input logic mtx);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {6'd0, mtx, pri, tid};
		// tready is stable at the falling edge, so the next rising edge accepts
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// result side: random stall before each item
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			@(negedge clk);
			m_tready = 1'b0;
			repeat (gap) @(negedge clk);
			m_tready = 1'b1;
			while (!m_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	initial begin
		int waited;
		int roll;
		logic [1:0] mode;
		logic [4:0] tid;
		logic [3:0] pri;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_READY;
		sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, every mode, rejected requests
		send_request(MODE_ROTATE, 5'd0, 4'd0, 1'b0);     // rotate with nothing ready
		send_request(MODE_UNREADY, 5'd31, 4'd0, 1'b0);   // remove of a task not ready
		send_request(MODE_PRIO, 5'd31, 4'd15, 1'b1);     // level change of idle task only
		send_request(MODE_READY, 5'd0, 4'd15, 1'b0);
		send_request(MODE_READY, 5'd0, 4'd15, 1'b0);     // already ready
		send_request(MODE_ROTATE, 5'd31, 4'd15, 1'b1);   // single task level
		send_request(MODE_READY, 5'd31, 4'd0, 1'b1);
		send_request(MODE_READY, 5'd5, 4'd0, 1'b0);
		send_request(MODE_READY, 5'd6, 4'd0, 1'b0);
		send_request(MODE_ROTATE, 5'd0, 4'd0, 1'b0);     // head of top level moves back
		send_request(MODE_PRIO, 5'd6, 4'd0, 1'b1);       // mutex tie takes the top
		send_request(MODE_PRIO, 5'd6, 4'd15, 1'b0);      // top task drops
		send_request(MODE_PRIO, 5'd0, 4'd0, 1'b1);
		send_request(MODE_PRIO, 5'd5, 4'd7, 1'b0);
		send_request(MODE_UNREADY, 5'd0, 4'd0, 1'b0);
		send_request(MODE_UNREADY, 5'd31, 4'd15, 1'b1);
		send_request(MODE_UNREADY, 5'd5, 4'd0, 1'b0);
		send_request(MODE_UNREADY, 5'd6, 4'd0, 1'b0);
		send_request(MODE_UNREADY, 5'd6, 4'd0, 1'b0);

		// random: mostly small task and level sets so queues grow deep
		repeat (1850) begin
			roll = $urandom_range(0, 99);
			mode = roll < 38 ? MODE_READY : roll < 64 ? MODE_UNREADY :
				roll < 84 ? MODE_PRIO : MODE_ROTATE;
			tid = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 11));
			pri = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
			send_request(mode, tid, pri, 1'($urandom));
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		waited = 0;
		while (pending != 0 && waited < 10000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
		$display("sent %0d requests over all four modes, rejected cases included", sent);
		$display("random stalls on both channels, results checked in order");
		if (fails == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/prqs_pkg.sv
rtl/core/prqs_datapath.sv
rtl/core/prqs_ctrl.sv
rtl/core/priority_ready_queue_scheduler.sv
sim/scheduler_checker.sv
sim/testbench.sv
